FILE: design/arpc_pkg.sv
// ----------------------------------------------------------------------------
// ARP cache package
// Shared types, sizes and codes for the ARP cache table and its cells.
// ----------------------------------------------------------------------------
package arpc_pkg;

    // Number of slots in the table; every slot is one cell of the ring.
    localparam int TABLE_ENTRIES = 64;
    localparam int SLOT_W        = $clog2(TABLE_ENTRIES);

    localparam int IP_W          = 32;
    localparam int MAC_W         = 48;
    localparam int TIME_W        = 32;
    localparam int TIMEOUT_W     = 16;
    localparam int SLOT_OUT_W    = 6;
    localparam int COUNT_W       = 7;

    localparam logic [COUNT_W-1:0]   COUNT_MAX     = '1;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd15;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // One table slot as it travels round the ring.
    typedef struct packed {
        logic              valid;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [TIME_W-1:0] added;
    } entry_t;

    // Result of one operation, handed from the sequencer to the ports.
    typedef struct packed {
        logic                  done;
        logic                  hit;
        logic [MAC_W-1:0]      found_mac;
        logic                  stored;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [COUNT_W-1:0]    expired_count;
    } result_t;

endpackage

FILE: design/arp_cache_table.sv
// ----------------------------------------------------------------------------
// ARP cache table with aging
// Maps IPv4 to MAC addresses in a ring of slot cells; lookup, insert and a
// one-second tick that expires old entries.
// ----------------------------------------------------------------------------
//
//  channel   signals                               handshake
//  -------   -----------------------------------   ---------------------------
//  command   operation, ip_addr, mac_addr          start high while busy low
//  result    hit, found_mac, stored, slot_index,   done high for one cycle
//            expired_count
//  config    cfg_wdata (entry_timeout)             cfg_we, taken at once
//
//  For each beat the ring of slot cells turns once, one slot past the
//  sequencer per cycle; the result is then presented in the done state,
//  and busy is low again in the idle state that follows, where the next
//  command beat can be taken.
//  Reset clears every valid bit, the seconds counter and sets the timeout
//  to 15; the table is usable in the first cycle after reset.
//  The receiver cannot stall: the result fields are valid only while done
//  is high; busy stays high through that cycle and drops in the next.
//
module arp_cache_table
    import arpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            operation,
    input  logic [IP_W-1:0]       ip_addr,
    input  logic [MAC_W-1:0]      mac_addr,

    output logic                  done,
    output logic                  hit,
    output logic [MAC_W-1:0]      found_mac,
    output logic                  stored,
    output logic [SLOT_OUT_W-1:0] slot_index,
    output logic [COUNT_W-1:0]    expired_count,

    input  logic                  cfg_we,
    input  logic [TIMEOUT_W-1:0]  cfg_wdata
);

    logic [TIMEOUT_W-1:0] timeout_reg;

    entry_t  cell_q [TABLE_ENTRIES];
    entry_t  cell_d [TABLE_ENTRIES];
    entry_t  tail;
    logic    shift_en;
    result_t result;

    // Timeout register; the user must write it only between beats, the block itself does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            timeout_reg <= cfg_wdata;
        end
    end

    // Ring of slots: each cell takes its upper neighbour, the last cell takes
    // the slot that the sequencer hands back after working on cell 0.
    // After one full turn every slot is back at its own place.
    generate
        for (genvar i = 0; i < TABLE_ENTRIES; i++)
        begin : g_cell
            if (i == TABLE_ENTRIES - 1)
            begin : g_last
                assign cell_d[i] = tail;
            end
            else
            begin : g_mid
                assign cell_d[i] = cell_q[i+1];
            end

            arpc_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .d        (cell_d[i]),
                .q        (cell_q[i])
            );
        end
    endgenerate

    // Sequencer: count the turn, match, fill or age the slot at the head
    arpc_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .operation     (operation),
        .ip_addr       (ip_addr),
        .mac_addr      (mac_addr),
        .entry_timeout (timeout_reg),
        .head          (cell_q[0]),
        .tail          (tail),
        .shift_en      (shift_en),
        .busy          (busy),
        .result        (result)
    );

    assign done          = result.done;
    assign hit           = result.hit;
    assign found_mac     = result.found_mac;
    assign stored        = result.stored;
    assign slot_index    = result.slot_index;
    assign expired_count = result.expired_count;

endmodule

FILE: design/arpc_cell.sv
// ----------------------------------------------------------------------------
// ARP cache cell
// One table slot; takes the slot of its neighbour whenever the ring turns.
// ----------------------------------------------------------------------------
module arpc_cell
    import arpc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   shift_en,
    input  entry_t d,
    output entry_t q
);

    logic                valid_reg;
    logic [IP_W-1:0]     ip_reg;
    logic [MAC_W-1:0]    mac_reg;
    logic [TIME_W-1:0]   added_reg;

    // Valid bit is cleared by reset: an empty table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            valid_reg <= d.valid;
        end
    end

    // Payload only matters behind a set valid bit
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            ip_reg    <= d.ip;
            mac_reg   <= d.mac;
            added_reg <= d.added;
        end
    end

    assign q = '{valid: valid_reg, ip: ip_reg, mac: mac_reg, added: added_reg};

endmodule

FILE: design/arpc_ctrl.sv
// ----------------------------------------------------------------------------
// ARP cache sequencer
// Turns the ring once per operation and works on the slot at its head.
// ----------------------------------------------------------------------------
module arpc_ctrl
    import arpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           operation,
    input  logic [IP_W-1:0]      ip_addr,
    input  logic [MAC_W-1:0]     mac_addr,
    input  logic [TIMEOUT_W-1:0] entry_timeout,
    input  entry_t               head,
    output entry_t               tail,
    output logic                 shift_en,
    output logic                 busy,
    output result_t              result
);

    state_t               state_reg, state_next;
    logic [SLOT_W-1:0]    step_reg, step_next;
    op_t                  op_reg, op_next;
    logic [IP_W-1:0]      ip_reg, ip_next;
    logic [MAC_W-1:0]     mac_reg, mac_next;
    logic [TIME_W-1:0]    seconds_reg, seconds_next;
    logic                 hit_reg, hit_next;
    logic [MAC_W-1:0]     found_reg, found_next;
    logic                 stored_reg, stored_next;
    logic [SLOT_W-1:0]    where_reg, where_next;
    logic [COUNT_W-1:0]   count_reg, count_next;

    logic [TIME_W-1:0]    age;
    logic                 last_step;

    assign age       = seconds_reg - head.added;
    assign last_step = (step_reg == SLOT_W'(TABLE_ENTRIES - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_step)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        busy     = 1'b1;
        shift_en = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_SCAN:
            begin
                shift_en = 1'b1;
            end
            ST_DONE:
            begin
                busy = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // Datapath: capture the beat, then inspect one slot per cycle
    always_comb
    begin
        step_next    = step_reg;
        op_next      = op_reg;
        ip_next      = ip_reg;
        mac_next     = mac_reg;
        seconds_next = seconds_reg;
        hit_next     = hit_reg;
        found_next   = found_reg;
        stored_next  = stored_reg;
        where_next   = where_reg;
        count_next   = count_reg;
        tail         = head;

        if (state_reg == ST_IDLE && start)
        begin
            op_next     = op_t'(operation);
            ip_next     = ip_addr;
            mac_next    = mac_addr;
            step_next   = '0;
            hit_next    = 1'b0;
            found_next  = '0;
            stored_next = 1'b0;
            where_next  = '0;
            count_next  = '0;
            if (op_t'(operation) == OP_TICK)
            begin
                seconds_next = seconds_reg + 1'b1;
            end
        end
        else if (state_reg == ST_SCAN)
        begin
            step_next = step_reg + 1'b1;
            case (op_reg)
                OP_LOOKUP:
                begin
                    // later slots overwrite earlier matches
                    if (head.valid && head.ip == ip_reg)
                    begin
                        hit_next   = 1'b1;
                        found_next = head.mac;
                        where_next = step_reg;
                    end
                end
                OP_INSERT:
                begin
                    // first free slot only
                    if (!stored_reg && !head.valid)
                    begin
                        tail        = '{valid: 1'b1, ip: ip_reg, mac: mac_reg,
                                        added: seconds_reg};
                        stored_next = 1'b1;
                        where_next  = step_reg;
                    end
                end
                OP_TICK:
                begin
                    if (head.valid && age > TIME_W'(entry_timeout))
                    begin
                        tail.valid = 1'b0;
                        if (count_reg != COUNT_MAX)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                OP_NONE:
                begin
                    tail = head;
                end
                default:
                begin
                    tail = head;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            seconds_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            seconds_reg <= seconds_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg   <= step_next;
        op_reg     <= op_next;
        ip_reg     <= ip_next;
        mac_reg    <= mac_next;
        hit_reg    <= hit_next;
        found_reg  <= found_next;
        stored_reg <= stored_next;
        where_reg  <= where_next;
        count_reg  <= count_next;
    end

    assign result = '{done:          (state_reg == ST_DONE),
                      hit:           hit_reg,
                      found_mac:     found_reg,
                      stored:        stored_reg,
                      slot_index:    SLOT_OUT_W'(where_reg),
                      expired_count: count_reg};

endmodule

FILE: design/arpc_checker.sv
// ----------------------------------------------------------------------------
// ARP cache port checker
// Watches the top level's ports over time.
// ----------------------------------------------------------------------------
module arpc_checker
    import arpc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  done,
    input logic                  hit,
    input logic [MAC_W-1:0]      found_mac,
    input logic                  stored,
    input logic [COUNT_W-1:0]    expired_count
);

    // A taken beat makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted beat");

    // Result strobe lasts one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // No new beat may be taken while a result is shown
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("busy low while result shown");

    // At most one kind of result per beat
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($countones({hit, stored, (expired_count != '0)}) <= 1))
        else $error("result mixes operation kinds");

    // Miss reports a zero MAC
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (found_mac == '0))
        else $error("non-zero MAC without hit");

endmodule

bind arp_cache_table arpc_checker u_arpc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .hit           (hit),
    .found_mac     (found_mac),
    .stored        (stored),
    .expired_count (expired_count)
);
